/* rtl/cpa_pkg.sv */
// shared types and constants of the contiguous page allocator
package cpa_pkg;

   localparam int PAGE_COUNT = 1024;
   localparam int PAGE_BYTES = 512;
   localparam int SLOT_COUNT = 16;

   localparam int ACTION_W = 2;
   localparam int PSLOT_W  = 4;
   localparam int LEN_W    = 20;
   localparam int INDEX_W  = 10;
   localparam int STATUS_W = 3;
   localparam int PHYS_W   = 10;
   localparam int COUNT_W  = 11;

   localparam int PAGE_W     = $clog2(PAGE_COUNT);
   localparam int CNT_W      = $clog2(PAGE_COUNT + 1);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int NEED_W     = LEN_W - PAGE_SHIFT + 1;
   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ALLOC  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_READ   = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_NOSPACE = 3'd1,
      ST_FREED   = 3'd2,
      ST_UNKNOWN = 3'd3,
      ST_BUSY    = 3'd4,
      ST_FULL    = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      WK_CLEAR = 2'd0,
      WK_CLAIM = 2'd1,
      WK_FREE  = 2'd2
   } wr_kind_type;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SCAN  = 3'b010,
      S_WRITE = 3'b100
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [PAGE_W-1:0] base;
      logic [CNT_W-1:0]  size;
      logic [CNT_W-1:0]  fill;
   } slot_entry_type;

   typedef struct packed {
      logic              set_en;
      logic              fill_en;
      logic              clr_en;
      logic [SLOT_W-1:0] slot;
      logic [PAGE_W-1:0] base;
      logic [CNT_W-1:0]  size;
      logic [CNT_W-1:0]  fill;
   } slot_wr_type;

endpackage

/* rtl/contiguous_page_allocator_unit.sv */
// top level: request decode, first-fit scan and page write sequencer
// append, in-range read and rejected requests: result in the next cycle, busy stays low
// allocate: bitmap scan at one page per cycle, then a write pass that marks each
//   claimed page as used
// free on out-of-range read: a write pass that marks each released page free, then the result
// after reset a clearing pass sets every page free, busy high
module contiguous_page_allocator_unit
   import cpa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [PSLOT_W-1:0]  req_proc_slot,
   input  logic [LEN_W-1:0]    req_byte_length,
   input  logic [INDEX_W-1:0]  req_page_index,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PHYS_W-1:0]   rsp_phys_page,
   output logic [COUNT_W-1:0]  rsp_page_count
);

   state_type         state_ff, state_in;
   wr_kind_type       kind_ff, kind_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [PAGE_W-1:0] chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]  run_ff, run_in;
   logic [CNT_W-1:0]  need_ff, need_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  last_ff, last_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [PHYS_W-1:0] pend_phys_ff, pend_phys_in;
   logic [COUNT_W-1:0] pend_cnt_ff, pend_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [PHYS_W-1:0] rsp_phys_ff, rsp_phys_in;
   logic [COUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   logic              accept;
   logic              slot_ok;
   logic [SLOT_W-1:0] req_slot;
   slot_entry_type    entry;
   slot_wr_type       slot_wr;
   logic [NEED_W-1:0] need_full;
   logic [CNT_W-1:0]  run_nx;
   logic [CNT_W-1:0]  found_base;
   logic              ram_wr_en;
   logic              ram_rd_en;
   logic              ram_q;

   assign accept   = start && (state_ff == S_IDLE);
   assign busy     = (state_ff != S_IDLE);
   assign slot_ok  = (32'(req_proc_slot) < SLOT_COUNT);
   assign req_slot = req_proc_slot[SLOT_W-1:0];

   assign need_full = (req_byte_length == '0) ? NEED_W'(1) :
                      NEED_W'((req_byte_length - LEN_W'(1)) >> PAGE_SHIFT) + NEED_W'(1);

   assign run_nx     = ram_q ? run_ff + CNT_W'(1) : '0;
   assign found_base = CNT_W'(chk_idx_ff) + CNT_W'(1) - need_ff;

   assign ram_rd_en = (state_ff == S_SCAN) && (32'(issue_ff) < PAGE_COUNT);
   assign ram_wr_en = (state_ff == S_WRITE) && (32'(ptr_ff) < PAGE_COUNT);

   cpa_page_ram u_page_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ptr_ff[PAGE_W-1:0]),
      .wr_data (kind_ff != WK_CLAIM),
      .rd_en   (ram_rd_en),
      .rd_addr (issue_ff[PAGE_W-1:0]),
      .rd_data (ram_q)
   );

   cpa_slot_table u_slot_table (
      .clock    (clock),
      .reset    (reset),
      .rd_slot  (req_slot),
      .rd_entry (entry),
      .wr       (slot_wr)
   );

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      issue_in      = issue_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      run_in        = run_ff;
      need_in       = need_ff;
      ptr_in        = ptr_ff;
      last_in       = last_ff;
      slot_in       = slot_ff;
      pend_phys_in  = pend_phys_ff;
      pend_cnt_in   = pend_cnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_phys_in   = rsp_phys_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      slot_wr       = '0;
      slot_wr.slot  = req_slot;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_action != ACT_NONE)) begin
               rsp_phys_in = '0;
               rsp_cnt_in  = '0;
               if (!slot_ok) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_UNKNOWN;
               end else begin
                  unique case (req_action)
                     ACT_ALLOC: begin
                        if (entry.valid) begin
                           rsp_valid_in  = 1'b1;
                           rsp_status_in = ST_BUSY;
                           rsp_phys_in   = PHYS_W'(entry.base);
                           rsp_cnt_in    = COUNT_W'(entry.size);
                        end else if (32'(need_full) > PAGE_COUNT) begin
                           rsp_valid_in  = 1'b1;
                           rsp_status_in = ST_NOSPACE;
                        end else begin
                           state_in = S_SCAN;
                           issue_in = '0;
                           run_in   = '0;
                           need_in  = CNT_W'(need_full);
                           slot_in  = req_slot;
                        end
                     end
                     ACT_APPEND: begin
                        rsp_valid_in = 1'b1;
                        if (!entry.valid) begin
                           rsp_status_in = ST_UNKNOWN;
                        end else if (entry.fill >= entry.size) begin
                           rsp_status_in = ST_FULL;
                           rsp_cnt_in    = COUNT_W'(entry.size);
                        end else begin
                           rsp_status_in   = ST_OK;
                           rsp_phys_in     = PHYS_W'(CNT_W'(entry.base) + entry.fill);
                           rsp_cnt_in      = COUNT_W'(entry.size);
                           slot_wr.fill_en = 1'b1;
                           slot_wr.fill    = entry.fill + CNT_W'(1);
                        end
                     end
                     ACT_READ: begin
                        if (!entry.valid) begin
                           rsp_valid_in  = 1'b1;
                           rsp_status_in = ST_UNKNOWN;
                        end else if (CNT_W'(req_page_index) < entry.size) begin
                           rsp_valid_in  = 1'b1;
                           rsp_status_in = ST_OK;
                           rsp_phys_in   = PHYS_W'(CNT_W'(entry.base) + CNT_W'(req_page_index));
                           rsp_cnt_in    = COUNT_W'(entry.size);
                        end else begin
                           state_in       = S_WRITE;
                           kind_in        = WK_FREE;
                           ptr_in         = CNT_W'(entry.base);
                           last_in        = CNT_W'(entry.base) + entry.size - CNT_W'(1);
                           pend_phys_in   = '0;
                           pend_cnt_in    = '0;
                           slot_wr.clr_en = 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         S_SCAN: begin
            if (ram_rd_en) begin
               issue_in   = issue_ff + CNT_W'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = issue_ff[PAGE_W-1:0];
            end
            if (chk_vld_ff) begin
               run_in = run_nx;
               if (run_nx == need_ff) begin
                  state_in        = S_WRITE;
                  kind_in         = WK_CLAIM;
                  ptr_in          = found_base;
                  last_in         = CNT_W'(chk_idx_ff);
                  pend_phys_in    = PHYS_W'(found_base);
                  pend_cnt_in     = COUNT_W'(need_ff);
                  slot_wr.set_en  = 1'b1;
                  slot_wr.slot    = slot_ff;
                  slot_wr.base    = found_base[PAGE_W-1:0];
                  slot_wr.size    = need_ff;
                  slot_wr.fill    = '0;
               end else if (32'(chk_idx_ff) == PAGE_COUNT - 1) begin
                  state_in      = S_IDLE;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NOSPACE;
                  rsp_phys_in   = '0;
                  rsp_cnt_in    = '0;
               end
            end
         end
         S_WRITE: begin
            ptr_in = ptr_ff + CNT_W'(1);
            if (ptr_ff == last_ff) begin
               state_in = S_IDLE;
               if (kind_ff != WK_CLEAR) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = (kind_ff == WK_CLAIM) ? ST_OK : ST_FREED;
                  rsp_phys_in   = pend_phys_ff;
                  rsp_cnt_in    = pend_cnt_ff;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_WRITE;
         kind_ff      <= WK_CLEAR;
         ptr_ff       <= '0;
         last_ff      <= CNT_W'(PAGE_COUNT - 1);
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         ptr_ff       <= ptr_in;
         last_ff      <= last_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff      <= issue_in;
      chk_idx_ff    <= chk_idx_in;
      run_ff        <= run_in;
      need_ff       <= need_in;
      slot_ff       <= slot_in;
      pend_phys_ff  <= pend_phys_in;
      pend_cnt_ff   <= pend_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_phys_ff   <= rsp_phys_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_phys_page  = rsp_phys_ff;
   assign rsp_page_count = rsp_cnt_ff;

endmodule

/* rtl/cpa_page_ram.sv */
// free-page bitmap memory, one write and one registered read port
module cpa_page_ram
   import cpa_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [PAGE_W-1:0] wr_addr,
   input  logic              wr_data,
   input  logic              rd_en,
   input  logic [PAGE_W-1:0] rd_addr,
   output logic              rd_data
);

   logic mem [PAGE_COUNT];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/cpa_slot_table.sv */
// process slot table: valid bits, base page, size and fill pointer
module cpa_slot_table
   import cpa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [SLOT_W-1:0] rd_slot,
   output slot_entry_type    rd_entry,
   input  slot_wr_type       wr
);

   logic [SLOT_COUNT-1:0] valid_ff;
   logic [PAGE_W-1:0]     base_ff [SLOT_COUNT];
   logic [CNT_W-1:0]      size_ff [SLOT_COUNT];
   logic [CNT_W-1:0]      fill_ff [SLOT_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.set_en) begin
         valid_ff[wr.slot] <= 1'b1;
      end else if (wr.clr_en) begin
         valid_ff[wr.slot] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.set_en) begin
         base_ff[wr.slot] <= wr.base;
         size_ff[wr.slot] <= wr.size;
      end
      if (wr.set_en || wr.fill_en) begin
         fill_ff[wr.slot] <= wr.fill;
      end
   end

   always_comb begin
      rd_entry.valid = valid_ff[rd_slot];
      rd_entry.base  = base_ff[rd_slot];
      rd_entry.size  = size_ff[rd_slot];
      rd_entry.fill  = fill_ff[rd_slot];
   end

endmodule

/* rtl/cpa_checker.sv */
// port-level checker of the page allocator, bound to the top level
module cpa_checker
   import cpa_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic [ACTION_W-1:0] req_action,
   input logic                rsp_valid,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [PHYS_W-1:0]   rsp_phys_page,
   input logic [COUNT_W-1:0]  rsp_page_count
);

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_FULL))
      else $error("result status out of range");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_NOSPACE || rsp_status == ST_FREED ||
                    rsp_status == ST_UNKNOWN)
      |-> (rsp_phys_page == '0) && (rsp_page_count == '0))
      else $error("failed transaction carries a page or count");

   a_no_action_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_action == ACT_NONE) |=> !rsp_valid)
      else $error("result for an unused action code");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_BUSY) |-> (rsp_page_count != '0))
      else $error("full or busy result with no pages");

   a_reset_busy: assert property (@(posedge clock)
      $past(reset) && !reset |-> busy)
      else $error("not busy during the clearing pass");

endmodule

bind contiguous_page_allocator_unit cpa_checker u_cpa_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_action     (req_action),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_phys_page  (rsp_phys_page),
   .rsp_page_count (rsp_page_count)
);

/* tb/sv/tb.sv */
// testbench for the contiguous page allocator: directed and random requests against a predictor
`timescale 1ns / 100ps

module tb;
   import cpa_pkg::*;

   localparam int ITEM_TARGET   = 580;
   localparam int SETTLE_CYCLES = 2 * PAGE_COUNT + 8;
   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      status_type          status;
      logic [PHYS_W-1:0]   phys_page;
      logic [COUNT_W-1:0]  page_count;
   } page_reply_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [ACTION_W-1:0] req_action = '0;
   logic [PSLOT_W-1:0]  req_proc_slot = '0;
   logic [LEN_W-1:0]    req_byte_length = '0;
   logic [INDEX_W-1:0]  req_page_index = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [PHYS_W-1:0]   rsp_phys_page;
   logic [COUNT_W-1:0]  rsp_page_count;

   // allocator image kept by the predictor
   logic [PAGE_COUNT-1:0] page_free = '1;
   logic [SLOT_COUNT-1:0] slot_valid = '0;
   logic [PAGE_W-1:0]     slot_base [SLOT_COUNT];
   logic [CNT_W-1:0]      slot_size [SLOT_COUNT];
   logic [CNT_W-1:0]      slot_fill [SLOT_COUNT];

   page_reply_type expected_replies [$];
   int          failures = 0;
   int          requests_sent = 0;
   int          cycle_count = 0;
   bit          idling = 1'b1;

   contiguous_page_allocator_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_proc_slot   (req_proc_slot),
      .req_byte_length (req_byte_length),
      .req_page_index  (req_page_index),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_phys_page   (rsp_phys_page),
      .rsp_page_count  (rsp_page_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("error: %s", msg);
   endfunction

   function automatic int pages_for_length(input logic [LEN_W-1:0] len);
      return (len == '0) ? 1 : (int'(len) - 1) / PAGE_BYTES + 1;
   endfunction

   function automatic logic [LEN_W-1:0] rand_length();
      return LEN_W'($urandom);
   endfunction

   function automatic logic [INDEX_W-1:0] rand_index();
      return INDEX_W'($urandom);
   endfunction

   // first-fit allocation, append, translation and release on the allocator image
   function automatic void predict_reply(input action_type act, input logic [PSLOT_W-1:0] slot,
                                         input logic [LEN_W-1:0] len,
                                         input logic [INDEX_W-1:0] idx);
      page_reply_type r;
      int          need;
      int          run;
      int          base;
      bit          found;
      r.status     = ST_OK;
      r.phys_page  = '0;
      r.page_count = '0;
      run   = 0;
      base  = 0;
      found = 1'b0;
      if (act == ACT_NONE) return;
      if (int'(slot) >= SLOT_COUNT) begin
         r.status = ST_UNKNOWN;
      end else begin
         case (act)
            ACT_ALLOC: begin
               if (slot_valid[slot]) begin
                  r.status     = ST_BUSY;
                  r.phys_page  = PHYS_W'(slot_base[slot]);
                  r.page_count = COUNT_W'(slot_size[slot]);
               end else begin
                  need = pages_for_length(len);
                  if (need <= PAGE_COUNT) begin
                     for (int i = 0; i < PAGE_COUNT && !found; i++) begin
                        run = page_free[i] ? run + 1 : 0;
                        if (run == need) begin
                           found = 1'b1;
                           base  = i + 1 - need;
                        end
                     end
                  end
                  if (found) begin
                     for (int p = base; p < base + need; p++) page_free[p] = 1'b0;
                     slot_valid[slot] = 1'b1;
                     slot_base[slot]  = PAGE_W'(base);
                     slot_size[slot]  = CNT_W'(need);
                     slot_fill[slot]  = '0;
                     r.phys_page      = PHYS_W'(base);
                     r.page_count     = COUNT_W'(need);
                  end else begin
                     r.status = ST_NOSPACE;
                  end
               end
            end
            ACT_APPEND: begin
               if (!slot_valid[slot]) begin
                  r.status = ST_UNKNOWN;
               end else if (slot_fill[slot] >= slot_size[slot]) begin
                  r.status     = ST_FULL;
                  r.page_count = COUNT_W'(slot_size[slot]);
               end else begin
                  r.phys_page     = PHYS_W'(int'(slot_base[slot]) + int'(slot_fill[slot]));
                  r.page_count    = COUNT_W'(slot_size[slot]);
                  slot_fill[slot] = slot_fill[slot] + CNT_W'(1);
               end
            end
            default: begin
               if (!slot_valid[slot]) begin
                  r.status = ST_UNKNOWN;
               end else if (int'(idx) < int'(slot_size[slot])) begin
                  r.phys_page  = PHYS_W'(int'(slot_base[slot]) + int'(idx));
                  r.page_count = COUNT_W'(slot_size[slot]);
               end else begin
                  for (int i = 0; i < int'(slot_size[slot]); i++) begin
                     base = int'(slot_base[slot]) + i;
                     if (base < PAGE_COUNT) page_free[base] = 1'b1;
                  end
                  slot_valid[slot] = 1'b0;
                  r.status         = ST_FREED;
               end
            end
         endcase
      end
      expected_replies.push_back(r);
   endfunction

   // accepted transactions and replies, both taken at the rising edge
   always @(posedge clock) begin
      page_reply_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_replies.size() == 0) begin
               note_failure($sformatf("unexpected reply status %0d phys %0d count %0d",
                                      rsp_status, rsp_phys_page, rsp_page_count));
            end else begin
               want = expected_replies.pop_front();
               if (rsp_status !== want.status || rsp_phys_page !== want.phys_page ||
                   rsp_page_count !== want.page_count)
                  note_failure($sformatf(
                     "reply status %0d/%0d phys %0d/%0d count %0d/%0d (expected/actual)",
                     want.status, rsp_status, want.phys_page, rsp_phys_page,
                     want.page_count, rsp_page_count));
            end
         end
         if (start && !busy)
            predict_reply(action_type'(req_action), req_proc_slot, req_byte_length,
                          req_page_index);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
                  expected_replies.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic issue_request(input action_type act, input logic [PSLOT_W-1:0] slot,
                                input logic [LEN_W-1:0] len, input logic [INDEX_W-1:0] idx);
      while (idling && $urandom_range(99) < 18) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_action      <= act;
      req_proc_slot   <= slot;
      req_byte_length <= len;
      req_page_index  <= idx;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (act != ACT_NONE) requests_sent++;
   endtask

   task automatic wait_for_replies();
      start <= 1'b0;
      do @(posedge clock); while (expected_replies.size() != 0);
   endtask

   task automatic test_alloc_append_read();
      issue_request(ACT_ALLOC, 4'd0, 20'd0, rand_index());
      issue_request(ACT_APPEND, 4'd0, rand_length(), rand_index());
      issue_request(ACT_APPEND, 4'd0, rand_length(), rand_index());
      issue_request(ACT_READ, 4'd0, rand_length(), 10'd0);
      issue_request(ACT_ALLOC, 4'd0, 20'd100, rand_index());
      issue_request(ACT_ALLOC, 4'd1, 20'd512, rand_index());
      issue_request(ACT_ALLOC, 4'd2, 20'd513, rand_index());
      issue_request(ACT_ALLOC, 4'd3, 20'hFFFFF, rand_index());
      issue_request(ACT_APPEND, 4'd5, rand_length(), rand_index());
      issue_request(ACT_READ, 4'd5, rand_length(), 10'd0);
      issue_request(ACT_NONE, 4'd0, 20'hFFFFF, 10'd1023);
      issue_request(ACT_READ, 4'd1, rand_length(), 10'd1023);
      issue_request(ACT_READ, 4'd0, rand_length(), 10'd1);
      issue_request(ACT_READ, 4'd2, rand_length(), 10'd2);
   endtask

   task automatic test_first_fit();
      issue_request(ACT_ALLOC, 4'd0, 20'd1, rand_index());
      issue_request(ACT_ALLOC, 4'd1, 20'd1024, rand_index());
      issue_request(ACT_ALLOC, 4'd2, 20'd0, rand_index());
      issue_request(ACT_READ, 4'd1, rand_length(), 10'd5);
      issue_request(ACT_ALLOC, 4'd4, 20'd1500, rand_index());
      issue_request(ACT_ALLOC, 4'd5, 20'd600, rand_index());
      issue_request(ACT_ALLOC, 4'd6, 20'd523264, rand_index());
      issue_request(ACT_READ, 4'd0, rand_length(), 10'd1023);
      issue_request(ACT_READ, 4'd2, rand_length(), 10'd1023);
      issue_request(ACT_READ, 4'd4, rand_length(), 10'd1023);
      issue_request(ACT_READ, 4'd5, rand_length(), 10'd1023);
   endtask

   // allocate, fill, translate and mostly release one process
   task automatic run_process_session();
      logic [PSLOT_W-1:0] slot;
      logic [LEN_W-1:0]   len;
      int                 pages;
      int                 pick;
      slot = PSLOT_W'($urandom_range(SLOT_COUNT - 1));
      pick = $urandom_range(99);
      if (pick < 70) len = LEN_W'($urandom_range(4096));
      else if (pick < 92) len = LEN_W'($urandom_range(32768));
      else len = rand_length();
      pages = pages_for_length(len);
      issue_request(ACT_ALLOC, slot, len, rand_index());
      repeat ($urandom_range(0, (pages > 9) ? 10 : pages + 1))
         issue_request(ACT_APPEND, slot, rand_length(), rand_index());
      repeat ($urandom_range(1, 4))
         issue_request(ACT_READ, slot, rand_length(),
                       INDEX_W'($urandom_range(0, ((pages > PAGE_COUNT) ? PAGE_COUNT : pages) - 1)));
      if ($urandom_range(99) < 65 && pages < PAGE_COUNT)
         issue_request(ACT_READ, slot, rand_length(), INDEX_W'($urandom_range(1023, pages)));
   endtask

   task automatic test_random_traffic();
      bit paused;
      paused = 1'b0;
      while (requests_sent < ITEM_TARGET - 10) begin
         idling = !(requests_sent >= 250 && requests_sent < 380);
         if (!paused && requests_sent >= 300) begin
            wait_for_replies();
            paused = 1'b1;
         end
         if ($urandom_range(99) < 15)
            issue_request(action_type'($urandom_range(3)), PSLOT_W'($urandom), rand_length(),
                          rand_index());
         else
            run_process_session();
      end
      idling = 1'b1;
   endtask

   // release what is left, then claim every page at once
   task automatic test_whole_memory();
      wait_for_replies();
      for (int s = 0; s < SLOT_COUNT; s++)
         if (slot_valid[s])
            issue_request(ACT_READ, PSLOT_W'(s), rand_length(), 10'd1023);
      issue_request(ACT_ALLOC, 4'd0, 20'd524288, rand_index());
      issue_request(ACT_ALLOC, 4'd1, 20'd0, rand_index());
      issue_request(ACT_APPEND, 4'd0, rand_length(), rand_index());
      issue_request(ACT_READ, 4'd0, rand_length(), 10'd1023);
      issue_request(ACT_ALLOC, 4'd0, 20'd1, rand_index());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_alloc_append_read();
      test_first_fit();
      wait_for_replies();
      test_random_traffic();
      test_whole_memory();
      wait_for_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_replies.size() != 0)
         note_failure($sformatf("%0d replies never arrived", expected_replies.size()));
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
